@@ sv/xlsa_pkg.sv @@
// Shared types and constants of the x86 logic and shift ALU.
package xlsa_pkg;

  localparam int unsigned DataW    = 32;
  localparam int unsigned CountW   = 5;
  localparam int unsigned InTdataW = 72;
  localparam int unsigned InTuserW = 3;
  localparam int unsigned OutTdataW = 40;

  typedef enum logic [2:0] {
    OP_AND  = 3'd0,
    OP_OR   = 3'd1,
    OP_XOR  = 3'd2,
    OP_TEST = 3'd3,
    OP_NOT  = 3'd4,
    OP_SHL  = 3'd5,
    OP_SHR  = 3'd6,
    OP_SAR  = 3'd7
  } op_e;

  localparam logic [1:0] WIDTH_BYTE  = 2'd0;
  localparam logic [1:0] WIDTH_WORD  = 2'd1;
  localparam logic [1:0] WIDTH_DWORD = 2'd2;

  localparam logic [DataW-1:0] MASK_BYTE  = 32'h0000_00FF;
  localparam logic [DataW-1:0] MASK_WORD  = 32'h0000_FFFF;
  localparam logic [DataW-1:0] MASK_DWORD = 32'hFFFF_FFFF;

  typedef struct packed {
    logic carry;
    logic overflow;
    logic zero;
    logic sign;
  } flags_t;

  typedef struct packed {
    op_e              req_type;
    logic [1:0]       width_code;
    logic [DataW-1:0] dest_value;
    logic [DataW-1:0] src_value;
    flags_t           flags;
  } req_t;

  typedef struct packed {
    logic [DataW-1:0] result_value;
    logic             write_back;
    flags_t           flags;
  } rsp_t;

endpackage

@@ sv/xlsa_core.sv @@
// Combinational datapath: logic and shift operations with flag update.
module xlsa_core (
  input  xlsa_pkg::req_t req_i,
  output xlsa_pkg::rsp_t rsp_o
);

  logic [xlsa_pkg::DataW-1:0]   mask;
  logic [xlsa_pkg::DataW-1:0]   d;
  logic [xlsa_pkg::DataW-1:0]   s;
  logic [xlsa_pkg::DataW-1:0]   d_sext;
  logic [xlsa_pkg::CountW-1:0]  cnt;
  logic [2*xlsa_pkg::DataW-1:0] shl_wide;
  logic [xlsa_pkg::DataW-1:0]   shl_res;
  logic                         shl_cf;
  logic [xlsa_pkg::DataW-1:0]   shr_res;
  logic [xlsa_pkg::DataW-1:0]   sar_res;
  logic [xlsa_pkg::DataW-1:0]   res;
  logic                         res_top;
  logic                         wb;
  logic                         zs_upd;
  xlsa_pkg::flags_t             fl;

  always_comb begin
    case (req_i.width_code)
      xlsa_pkg::WIDTH_BYTE: begin
        mask = xlsa_pkg::MASK_BYTE;
      end
      xlsa_pkg::WIDTH_WORD: begin
        mask = xlsa_pkg::MASK_WORD;
      end
      default: begin
        mask = xlsa_pkg::MASK_DWORD;
      end
    endcase
  end

  assign d   = req_i.dest_value & mask;
  assign s   = req_i.src_value & mask;
  assign cnt = req_i.src_value[xlsa_pkg::CountW-1:0];

  assign shl_wide = {{xlsa_pkg::DataW{1'b0}}, d} << cnt;
  assign shl_res  = shl_wide[xlsa_pkg::DataW-1:0] & mask;
  assign shr_res  = d >> cnt;
  assign sar_res  = xlsa_pkg::DataW'($signed(d_sext) >>> cnt) & mask;

  always_comb begin
    case (req_i.width_code)
      xlsa_pkg::WIDTH_BYTE: begin
        d_sext = {{24{d[7]}}, d[7:0]};
        shl_cf = shl_wide[8];
      end
      xlsa_pkg::WIDTH_WORD: begin
        d_sext = {{16{d[15]}}, d[15:0]};
        shl_cf = shl_wide[16];
      end
      default: begin
        d_sext = d;
        shl_cf = shl_wide[32];
      end
    endcase
  end

  always_comb begin
    fl     = req_i.flags;
    wb     = 1'b1;
    zs_upd = 1'b1;
    res    = '0;
    case (req_i.req_type)
      xlsa_pkg::OP_AND: begin
        res = d & s;
        fl.carry = 1'b0;
        fl.overflow = 1'b0;
      end
      xlsa_pkg::OP_OR: begin
        res = d | s;
        fl.carry = 1'b0;
        fl.overflow = 1'b0;
      end
      xlsa_pkg::OP_XOR: begin
        res = d ^ s;
        fl.carry = 1'b0;
        fl.overflow = 1'b0;
      end
      xlsa_pkg::OP_TEST: begin
        res = d & s;
        fl.carry = 1'b0;
        fl.overflow = 1'b0;
        wb = 1'b0;
      end
      xlsa_pkg::OP_NOT: begin
        res = ~d & mask;
        zs_upd = 1'b0;
      end
      xlsa_pkg::OP_SHL: begin
        res = shl_res;
        if (cnt != '0) begin
          fl.carry = shl_cf;
        end
      end
      xlsa_pkg::OP_SHR: begin
        res = shr_res;
      end
      default: begin
        res = sar_res;
      end
    endcase
  end

  always_comb begin
    case (req_i.width_code)
      xlsa_pkg::WIDTH_BYTE: begin
        res_top = res[7];
      end
      xlsa_pkg::WIDTH_WORD: begin
        res_top = res[15];
      end
      default: begin
        res_top = res[31];
      end
    endcase
  end

  always_comb begin
    rsp_o.result_value = res;
    rsp_o.write_back   = wb;
    rsp_o.flags        = fl;
    if (req_i.req_type == xlsa_pkg::OP_SHL && cnt == xlsa_pkg::CountW'(1)) begin
      rsp_o.flags.overflow = res_top ^ fl.carry;
    end
    if (zs_upd) begin
      rsp_o.flags.zero = (res == '0);
      rsp_o.flags.sign = res_top;
    end
  end

endmodule

@@ sv/x86_logic_shift_alu_unit.sv @@
// Top level of the x86 logic and shift ALU: input register, datapath, result register.
// A request goes from the input register to the result register, then to the master side.
// Throughput: one request per cycle unless the master side stalls; the input and result
// registers advance together; a full input register holds while the result is stalled.
// Reset: asynchronous, active low; clears both valid bits, payload is not reset.
module x86_logic_shift_alu_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // width_code[1:0], dest_value[33:2], src_value[65:34], carry_in[66],
  // overflow_in[67], zero_in[68], sign_in[69], zero fill [71:70]
  input  logic [xlsa_pkg::InTdataW-1:0]    s_axis_tdata,
  // req_type[2:0]
  input  logic [xlsa_pkg::InTuserW-1:0]    s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // result_value[31:0], write_back[32], carry_out[33], overflow_out[34],
  // zero_out[35], sign_out[36], zero fill [39:37]
  output logic [xlsa_pkg::OutTdataW-1:0]   m_axis_tdata
);

  logic           in_valid_q;
  xlsa_pkg::req_t in_req_q;
  xlsa_pkg::req_t in_req_d;
  logic           out_valid_q;
  xlsa_pkg::rsp_t out_rsp_q;
  xlsa_pkg::rsp_t out_rsp_d;
  logic           out_ready;
  logic           in_ready;

  assign out_ready = !out_valid_q || m_axis_tready;
  assign in_ready  = !in_valid_q || out_ready;

  always_comb begin
    in_req_d.req_type       = xlsa_pkg::op_e'(s_axis_tuser);
    in_req_d.width_code     = s_axis_tdata[1:0];
    in_req_d.dest_value     = s_axis_tdata[33:2];
    in_req_d.src_value      = s_axis_tdata[65:34];
    in_req_d.flags.carry    = s_axis_tdata[66];
    in_req_d.flags.overflow = s_axis_tdata[67];
    in_req_d.flags.zero     = s_axis_tdata[68];
    in_req_d.flags.sign     = s_axis_tdata[69];
  end

  xlsa_core u_core (
    .req_i (in_req_q),
    .rsp_o (out_rsp_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (out_ready) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && s_axis_tvalid) begin
      in_req_q <= in_req_d;
    end
    if (out_ready && in_valid_q) begin
      out_rsp_q <= out_rsp_d;
    end
  end

  assign s_axis_tready = in_ready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000,
                          out_rsp_q.flags.sign,
                          out_rsp_q.flags.zero,
                          out_rsp_q.flags.overflow,
                          out_rsp_q.flags.carry,
                          out_rsp_q.write_back,
                          out_rsp_q.result_value};

endmodule

@@ sv/xlsa_checker.sv @@
// Port-level checker for the x86 logic and shift ALU, bound to the top level.
module xlsa_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [xlsa_pkg::OutTdataW-1:0] m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed or dropped while stalled");

  a_full_only_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("request side blocked without a stalled result");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("result appeared without a request two cycles earlier");

  a_test_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[32] |->
      !m_axis_tdata[33] && !m_axis_tdata[34] &&
      (m_axis_tdata[35] == (m_axis_tdata[31:0] == 32'd0)))
    else $error("test result carries wrong flags");

endmodule

bind x86_logic_shift_alu_unit xlsa_checker u_xlsa_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

@@ tb/tb.sv @@
// Self-checking stream testbench for the x86 logic and shift ALU unit.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0]  WIDTH_SPARE = 2'd3;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned RandomCount = 1500;
  localparam int unsigned IdlePct     = 19;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned HoldAtResult = 200;

  typedef struct {
    xlsa_pkg::req_t req;
    bit             wait_idle;
  } pending_req_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  // width_code, dest_value, src_value, carry_in, overflow_in, zero_in, sign_in, zero fill
  logic [xlsa_pkg::InTdataW-1:0]  s_axis_tdata = '0;
  // req_type
  logic [xlsa_pkg::InTuserW-1:0]  s_axis_tuser = '0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  // result_value, write_back, carry_out, overflow_out, zero_out, sign_out, zero fill
  logic [xlsa_pkg::OutTdataW-1:0] m_axis_tdata;

  pending_req_t   pending_q[$];
  xlsa_pkg::rsp_t alu_outcome_q[$];
  int unsigned    cycle_count = 0;
  int unsigned    mismatch_count = 0;
  int unsigned    sent_count = 0;
  int unsigned    result_count = 0;
  int unsigned    op_seen[8];
  int unsigned    hold_left = 0;
  bit             hold_done = 1'b0;
  logic           quiet;

  x86_logic_shift_alu_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  // no idling on either side inside this window
  assign quiet = (cycle_count >= 600) && (cycle_count < 1100);

  function automatic xlsa_pkg::rsp_t alu_outcome(xlsa_pkg::req_t r);
    logic [31:0]      mask;
    logic [31:0]      top;
    logic [31:0]      d;
    logic [31:0]      s;
    logic [31:0]      res;
    logic [63:0]      ext;
    logic [4:0]       cnt;
    int unsigned      w;
    xlsa_pkg::flags_t f;
    logic             wb;
    bit               set_zs;
    xlsa_pkg::rsp_t   o;
    case (r.width_code)
      xlsa_pkg::WIDTH_BYTE: begin
        w = 8;
        mask = xlsa_pkg::MASK_BYTE;
      end
      xlsa_pkg::WIDTH_WORD: begin
        w = 16;
        mask = xlsa_pkg::MASK_WORD;
      end
      default: begin
        w = 32;
        mask = xlsa_pkg::MASK_DWORD;
      end
    endcase
    top = 32'h1 << (w - 1);
    d = r.dest_value & mask;
    s = r.src_value & mask;
    cnt = r.src_value[4:0];
    f = r.flags;
    wb = 1'b1;
    set_zs = 1'b1;
    res = '0;
    case (r.req_type)
      xlsa_pkg::OP_AND: begin
        res = d & s;
        f.carry = 1'b0;
        f.overflow = 1'b0;
      end
      xlsa_pkg::OP_OR: begin
        res = d | s;
        f.carry = 1'b0;
        f.overflow = 1'b0;
      end
      xlsa_pkg::OP_XOR: begin
        res = d ^ s;
        f.carry = 1'b0;
        f.overflow = 1'b0;
      end
      xlsa_pkg::OP_TEST: begin
        res = d & s;
        f.carry = 1'b0;
        f.overflow = 1'b0;
        wb = 1'b0;
      end
      xlsa_pkg::OP_NOT: begin
        res = ~d & mask;
        set_zs = 1'b0;
      end
      xlsa_pkg::OP_SHL: begin
        res = (d << cnt) & mask;
        if (cnt != 0) begin
          f.carry = (cnt <= w) ? d[w - cnt] : 1'b0;
          if (cnt == 1) f.overflow = ((res & top) != 0) ^ f.carry;
        end
      end
      xlsa_pkg::OP_SHR: begin
        res = d >> cnt;
      end
      default: begin
        ext = {32'b0, d};
        if ((d & top) != 0) ext = ext | ~{32'b0, mask};
        res = 32'(ext >> cnt) & mask;
      end
    endcase
    if (set_zs) begin
      f.zero = (res == 0);
      f.sign = ((res & top) != 0);
    end
    o.result_value = res;
    o.write_back = wb;
    o.flags = f;
    return o;
  endfunction

  task automatic add_request(xlsa_pkg::op_e op, logic [1:0] wc, logic [31:0] d,
                             logic [31:0] s, xlsa_pkg::flags_t f, bit wait_idle);
    pending_req_t p;
    p.req.req_type = op;
    p.req.width_code = wc;
    p.req.dest_value = d;
    p.req.src_value = s;
    p.req.flags = f;
    p.wait_idle = wait_idle;
    pending_q.push_back(p);
  endtask

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 7))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: begin
        case ($urandom_range(0, 2))
          0: return 32'h80;
          1: return 32'h8000;
          default: return 32'h8000_0000;
        endcase
      end
      3: return 32'h1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_count();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: begin
        case ($urandom_range(0, 6))
          0: return 32'd0;
          1: return 32'd1;
          2: return 32'd8;
          3: return 32'd9;
          4: return 32'd16;
          5: return 32'd17;
          default: return 32'd31;
        endcase
      end
      default: return 32'($urandom_range(0, 31));
    endcase
  endfunction

  task automatic report_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("mismatch on %s at result %0d: expected %h, got %h",
                 name, result_count, want, got);
    end
  endtask

  always @(posedge clk_i) begin : drive
    bit offer;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        alu_outcome_q.push_back(alu_outcome(pending_q[0].req));
        op_seen[pending_q[0].req.req_type]++;
        pending_q.pop_front();
        sent_count++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        offer = (pending_q.size() != 0) && (quiet || $urandom_range(0, 99) >= IdlePct);
        // hold back until the pipe has drained
        if (offer && pending_q[0].wait_idle && alu_outcome_q.size() != 0) offer = 1'b0;
        if (offer) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {2'b00, pending_q[0].req.flags.sign, pending_q[0].req.flags.zero,
                           pending_q[0].req.flags.overflow, pending_q[0].req.flags.carry,
                           pending_q[0].req.src_value, pending_q[0].req.dest_value,
                           pending_q[0].req.width_code};
          s_axis_tuser <= pending_q[0].req.req_type;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : watch
    xlsa_pkg::rsp_t got;
    xlsa_pkg::rsp_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.result_value = m_axis_tdata[31:0];
        got.write_back = m_axis_tdata[32];
        got.flags.carry = m_axis_tdata[33];
        got.flags.overflow = m_axis_tdata[34];
        got.flags.zero = m_axis_tdata[35];
        got.flags.sign = m_axis_tdata[36];
        result_count++;
        if (alu_outcome_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result %h with no request outstanding", m_axis_tdata);
        end else begin
          want = alu_outcome_q.pop_front();
          report_field("result_value", want.result_value, got.result_value);
          report_field("write_back", 32'(want.write_back), 32'(got.write_back));
          report_field("carry_out", 32'(want.flags.carry), 32'(got.flags.carry));
          report_field("overflow_out", 32'(want.flags.overflow), 32'(got.flags.overflow));
          report_field("zero_out", 32'(want.flags.zero), 32'(got.flags.zero));
          report_field("sign_out", 32'(want.flags.sign), 32'(got.flags.sign));
        end
        if (result_count == HoldAtResult && !hold_done) begin
          hold_left = HoldCycles;
          hold_done = 1'b1;
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= quiet || ($urandom_range(0, 99) >= IdlePct);
      end
    end
  end

  initial begin
    while (cycle_count < CycleLimit) @(posedge clk_i);
    $display("x86_logic_shift_alu_unit verification failed");
    $finish;
  end

  initial begin
    xlsa_pkg::op_e op;
    logic [1:0]    wc;
    logic [31:0]   d;
    logic [31:0]   s;

    add_request(xlsa_pkg::OP_AND, xlsa_pkg::WIDTH_DWORD, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                xlsa_pkg::flags_t'(4'b1111), 1'b0);
    add_request(xlsa_pkg::OP_AND, xlsa_pkg::WIDTH_BYTE, 32'hFFFF_FF00, 32'h0000_00FF,
                xlsa_pkg::flags_t'(4'b0000), 1'b0);
    add_request(xlsa_pkg::OP_OR, xlsa_pkg::WIDTH_WORD, 32'h0000_8000, 32'h0000_0000,
                xlsa_pkg::flags_t'(4'b1100), 1'b0);
    add_request(xlsa_pkg::OP_XOR, xlsa_pkg::WIDTH_DWORD, 32'h1234_5678, 32'h1234_5678,
                xlsa_pkg::flags_t'(4'b1010), 1'b0);
    add_request(xlsa_pkg::OP_TEST, xlsa_pkg::WIDTH_BYTE, 32'h0000_0080, 32'hFFFF_FFFF,
                xlsa_pkg::flags_t'(4'b1111), 1'b0);
    add_request(xlsa_pkg::OP_TEST, xlsa_pkg::WIDTH_DWORD, 32'h0000_0000, 32'h0000_0000,
                xlsa_pkg::flags_t'(4'b0000), 1'b0);
    add_request(xlsa_pkg::OP_NOT, xlsa_pkg::WIDTH_DWORD, 32'h0000_0000, 32'h0000_0000,
                xlsa_pkg::flags_t'(4'b1111), 1'b0);
    add_request(xlsa_pkg::OP_NOT, xlsa_pkg::WIDTH_BYTE, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                xlsa_pkg::flags_t'(4'b0000), 1'b0);
    add_request(xlsa_pkg::OP_SHL, xlsa_pkg::WIDTH_BYTE, 32'h0000_0081, 32'd1,
                xlsa_pkg::flags_t'(4'b0000), 1'b0);
    add_request(xlsa_pkg::OP_SHL, xlsa_pkg::WIDTH_WORD, 32'h0000_4000, 32'd1,
                xlsa_pkg::flags_t'(4'b0000), 1'b0);
    add_request(xlsa_pkg::OP_SHL, xlsa_pkg::WIDTH_DWORD, 32'h0000_0001, 32'd31,
                xlsa_pkg::flags_t'(4'b0000), 1'b0);
    add_request(xlsa_pkg::OP_SHL, xlsa_pkg::WIDTH_BYTE, 32'h0000_0001, 32'd8,
                xlsa_pkg::flags_t'(4'b0000), 1'b0);
    add_request(xlsa_pkg::OP_SHL, xlsa_pkg::WIDTH_BYTE, 32'h0000_00FF, 32'd9,
                xlsa_pkg::flags_t'(4'b1111), 1'b0);
    add_request(xlsa_pkg::OP_SHL, xlsa_pkg::WIDTH_DWORD, 32'hFFFF_FFFF, 32'd32,
                xlsa_pkg::flags_t'(4'b1111), 1'b0);
    add_request(xlsa_pkg::OP_SHL, xlsa_pkg::WIDTH_WORD, 32'h0000_8001, 32'd2,
                xlsa_pkg::flags_t'(4'b0100), 1'b0);
    add_request(xlsa_pkg::OP_SHR, xlsa_pkg::WIDTH_DWORD, 32'h8000_0000, 32'd31,
                xlsa_pkg::flags_t'(4'b1100), 1'b0);
    add_request(xlsa_pkg::OP_SHR, xlsa_pkg::WIDTH_BYTE, 32'h0000_0080, 32'd0,
                xlsa_pkg::flags_t'(4'b1111), 1'b0);
    add_request(xlsa_pkg::OP_SHR, xlsa_pkg::WIDTH_WORD, 32'h0000_FFFF, 32'd20,
                xlsa_pkg::flags_t'(4'b0000), 1'b0);
    add_request(xlsa_pkg::OP_SHR, xlsa_pkg::WIDTH_DWORD, 32'hFFFF_FFFF, 32'hFFFF_FFE1,
                xlsa_pkg::flags_t'(4'b0110), 1'b0);
    add_request(xlsa_pkg::OP_SAR, xlsa_pkg::WIDTH_BYTE, 32'h0000_0080, 32'd7,
                xlsa_pkg::flags_t'(4'b0000), 1'b0);
    add_request(xlsa_pkg::OP_SAR, xlsa_pkg::WIDTH_WORD, 32'h0000_8000, 32'd31,
                xlsa_pkg::flags_t'(4'b1111), 1'b0);
    add_request(xlsa_pkg::OP_SAR, xlsa_pkg::WIDTH_DWORD, 32'h8000_0000, 32'd1,
                xlsa_pkg::flags_t'(4'b0000), 1'b0);
    add_request(xlsa_pkg::OP_SAR, xlsa_pkg::WIDTH_BYTE, 32'h0000_007F, 32'd3,
                xlsa_pkg::flags_t'(4'b1001), 1'b0);
    add_request(xlsa_pkg::OP_XOR, WIDTH_SPARE, 32'hFFFF_FFFF, 32'h0F0F_0F0F,
                xlsa_pkg::flags_t'(4'b1111), 1'b0);
    add_request(xlsa_pkg::OP_SHL, WIDTH_SPARE, 32'h8000_0000, 32'd1,
                xlsa_pkg::flags_t'(4'b0000), 1'b0);

    for (int i = 0; i < RandomCount; i++) begin
      op = xlsa_pkg::op_e'($urandom_range(0, 7));
      wc = ($urandom_range(0, 15) == 0) ? WIDTH_SPARE : 2'($urandom_range(0, 2));
      d = pick_operand();
      s = (op == xlsa_pkg::OP_SHL || op == xlsa_pkg::OP_SHR || op == xlsa_pkg::OP_SAR) ?
          pick_count() : pick_operand();
      add_request(op, wc, d, s, xlsa_pkg::flags_t'(4'($urandom)), i == 900);
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_q.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (alu_outcome_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Covered %0d requests (and %0d, or %0d, xor %0d, test %0d, not %0d, shl %0d,",
             sent_count, op_seen[xlsa_pkg::OP_AND], op_seen[xlsa_pkg::OP_OR],
             op_seen[xlsa_pkg::OP_XOR], op_seen[xlsa_pkg::OP_TEST],
             op_seen[xlsa_pkg::OP_NOT], op_seen[xlsa_pkg::OP_SHL]);
    $display("  shr %0d, sar %0d) with %0d results checked and %0d mismatches",
             op_seen[xlsa_pkg::OP_SHR], op_seen[xlsa_pkg::OP_SAR], result_count,
             mismatch_count);
    if (mismatch_count == 0 && alu_outcome_q.size() == 0) begin
      $display("x86_logic_shift_alu_unit verification clean");
    end else begin
      $display("x86_logic_shift_alu_unit verification failed");
    end
    $finish;
  end

endmodule
